/* sv/rle4d_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rle4d_pkg
// Shared types and constants for the 4-bit RLE bitmap decoder.
// ----------------------------------------------------------------------------
package rle4d_pkg;

	localparam int MAX_WIDTH  = 1024;
	localparam int MAX_HEIGHT = 4096;

	// position registers must hold the saturation value itself
	localparam int COL_W = $clog2(MAX_WIDTH + 1);
	localparam int ROW_W = $clog2(MAX_HEIGHT + 1);

	localparam int IMG_W_W   = 11;
	localparam int IMG_H_W   = 13;
	localparam int CFG_W     = 13;
	localparam int CFG_IDX_W = 2;

	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;

	localparam logic [IMG_W_W-1:0] WIDTH_RESET  = 11'd320;
	localparam logic [IMG_H_W-1:0] HEIGHT_RESET = 13'd240;

	localparam logic [7:0] HI_MASK = 8'hF0;
	localparam logic [7:0] LO_MASK = 8'h0F;

	localparam logic [7:0] ESC_EOL   = 8'd0;
	localparam logic [7:0] ESC_EOI   = 8'd1;
	localparam logic [7:0] ESC_DELTA = 8'd2;

	localparam logic [11:0] ROW_OUT_MAX = 12'd4095;
	localparam logic [9:0]  COL_OUT_MAX = 10'd1023;

	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);

	typedef enum logic [2:0] {
		PH_COUNT,
		PH_VALUE,
		PH_ESCAPE,
		PH_DELTA_X,
		PH_DELTA_Y,
		PH_ABS_DATA,
		PH_ABS_PAD
	} phase_t;

	typedef enum logic [2:0] {
		OP_NOP,
		OP_RUN,
		OP_EOL,
		OP_EOI,
		OP_DELTA
	} op_t;

	// RUN: arg_a = requested length, arg_b = pixel byte
	// DELTA: arg_a = dx, arg_b = dy
	typedef struct packed {
		op_t        op;
		logic       frame_rst;
		logic [7:0] arg_a;
		logic [7:0] arg_b;
	} cmd_t;

	typedef struct packed {
		logic empty;
		logic full;
	} fifo_stat_t;

	typedef struct packed {
		logic [11:0] row;
		logic [9:0]  column;
		logic [7:0]  run_length;
		logic [3:0]  first_index;
		logic [3:0]  second_index;
		logic        end_of_image;
		logic        overflow;
	} result_t;

endpackage

/* sv/rle4d_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rle4d_front
// Byte parser: tracks the RLE4 phase and turns each request into a command.
// ----------------------------------------------------------------------------
module rle4d_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [7:0]        data_byte,
	input  logic              frame_start,
	input  rle4d_pkg::fifo_stat_t fifo_stat,
	output logic              push,
	output rle4d_pkg::cmd_t   cmd
);
	import rle4d_pkg::*;

	phase_t     phase_q, phase_e, phase_d;
	logic [7:0] held_q, held_e, held_d;
	logic [7:0] dx_q, dx_e, dx_d;
	logic [7:0] abs_q, abs_e, abs_d;
	logic       pad_q, pad_e, pad_d;
	logic       done_q, done_e, done_d;
	logic [7:0] abs_len;
	logic [7:0] abs_rem;
	logic [8:0] cnt_plus1;

	assign in_ready = !fifo_stat.full;
	assign push     = in_valid && in_ready;

	// frame_start clears the parser before this byte is decoded
	always_comb begin
		phase_e = frame_start ? PH_COUNT : phase_q;
		held_e  = frame_start ? 8'd0 : held_q;
		dx_e    = frame_start ? 8'd0 : dx_q;
		abs_e   = frame_start ? 8'd0 : abs_q;
		pad_e   = frame_start ? 1'b0 : pad_q;
		done_e  = frame_start ? 1'b0 : done_q;
	end

	assign abs_len   = (abs_e < 8'd2) ? abs_e : 8'd2;
	assign abs_rem   = abs_e - abs_len;
	assign cnt_plus1 = {1'b0, data_byte} + 9'd1;

	// next state
	always_comb begin
		phase_d = phase_e;
		held_d  = held_e;
		dx_d    = dx_e;
		abs_d   = abs_e;
		pad_d   = pad_e;
		done_d  = done_e;
		if (!done_e) begin
			case (phase_e)
				PH_VALUE: begin
					phase_d = PH_COUNT;
				end
				PH_ESCAPE: begin
					if (data_byte == ESC_EOL) begin
						phase_d = PH_COUNT;
					end else if (data_byte == ESC_EOI) begin
						done_d  = 1'b1;
						phase_d = PH_COUNT;
					end else if (data_byte == ESC_DELTA) begin
						phase_d = PH_DELTA_X;
					end else begin
						abs_d   = data_byte;
						// pad when the data byte count is odd
						pad_d   = cnt_plus1[1];
						phase_d = PH_ABS_DATA;
					end
				end
				PH_DELTA_X: begin
					dx_d    = data_byte;
					phase_d = PH_DELTA_Y;
				end
				PH_DELTA_Y: begin
					phase_d = PH_COUNT;
				end
				PH_ABS_DATA: begin
					abs_d = abs_rem;
					if (abs_rem == 8'd0) begin
						phase_d = pad_e ? PH_ABS_PAD : PH_COUNT;
					end
				end
				PH_ABS_PAD: begin
					pad_d   = 1'b0;
					phase_d = PH_COUNT;
				end
				default: begin
					if (data_byte == 8'd0) begin
						phase_d = PH_ESCAPE;
					end else begin
						held_d  = data_byte;
						phase_d = PH_VALUE;
					end
				end
			endcase
		end
	end

	// command out
	always_comb begin
		cmd.op        = OP_NOP;
		cmd.frame_rst = frame_start;
		cmd.arg_a     = 8'd0;
		cmd.arg_b     = data_byte;
		if (!done_e) begin
			case (phase_e)
				PH_VALUE: begin
					cmd.op    = OP_RUN;
					cmd.arg_a = held_e;
				end
				PH_ESCAPE: begin
					if (data_byte == ESC_EOL) begin
						cmd.op = OP_EOL;
					end else if (data_byte == ESC_EOI) begin
						cmd.op = OP_EOI;
					end else begin
						cmd.op = OP_NOP;
					end
				end
				PH_DELTA_Y: begin
					cmd.op    = OP_DELTA;
					cmd.arg_a = dx_e;
				end
				PH_ABS_DATA: begin
					cmd.op    = OP_RUN;
					cmd.arg_a = abs_len;
				end
				default: begin
					cmd.op = OP_NOP;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_COUNT;
			held_q  <= 8'd0;
			dx_q    <= 8'd0;
			abs_q   <= 8'd0;
			pad_q   <= 1'b0;
			done_q  <= 1'b0;
		end else if (push) begin
			phase_q <= phase_d;
			held_q  <= held_d;
			dx_q    <= dx_d;
			abs_q   <= abs_d;
			pad_q   <= pad_d;
			done_q  <= done_d;
		end
	end

endmodule

/* sv/rle4d_cmd_fifo.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rle4d_cmd_fifo
// Short command queue between the parser and the position unit.
// ----------------------------------------------------------------------------
module rle4d_cmd_fifo (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	input  rle4d_pkg::cmd_t       wr_cmd,
	input  logic                  pop,
	output rle4d_pkg::cmd_t       rd_cmd,
	output rle4d_pkg::fifo_stat_t stat
);
	import rle4d_pkg::*;

	cmd_t                  mem_q [FIFO_DEPTH];
	logic [FIFO_PTR_W-1:0] wr_ptr_q;
	logic [FIFO_PTR_W-1:0] rd_ptr_q;
	logic [FIFO_PTR_W:0]   count_q;

	assign stat.empty = (count_q == '0);
	assign stat.full  = (count_q == (FIFO_PTR_W+1)'(FIFO_DEPTH));
	assign rd_cmd     = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

/* sv/rle4d_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rle4d_back
// Position unit: holds column, row and image size, executes commands and
// registers the run descriptors.
// ----------------------------------------------------------------------------
module rle4d_back (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [rle4d_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [rle4d_pkg::CFG_W-1:0]   cfg_data,
	input  rle4d_pkg::cmd_t               head,
	input  rle4d_pkg::fifo_stat_t         fifo_stat,
	output logic                          pop,
	output logic                          out_valid,
	input  logic                          out_ready,
	output rle4d_pkg::result_t            res
);
	import rle4d_pkg::*;

	logic [IMG_W_W-1:0] width_q;
	logic [IMG_H_W-1:0] height_q;
	logic [COL_W-1:0]   col_q, col_b, col_d;
	logic [ROW_W-1:0]   row_q, row_b, row_d;
	logic [COL_W-1:0]   eff_w;
	logic [ROW_W-1:0]   eff_h;
	logic [COL_W-1:0]   avail;
	logic [7:0]         run_len;
	logic               clipped;
	logic               row_out;
	logic [31:0]        col_sum;
	logic [31:0]        row_sum;
	logic               emits;
	logic               out_free;
	logic               out_valid_q;
	result_t            res_d;
	result_t            res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= WIDTH_RESET;
			height_q <= HEIGHT_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_IMAGE_WIDTH:  width_q  <= cfg_data[IMG_W_W-1:0];
				REG_IMAGE_HEIGHT: height_q <= cfg_data[IMG_H_W-1:0];
				default: ;
			endcase
		end
	end

	// zero acts as one, oversize clamps to the maximum
	always_comb begin
		if (width_q == '0) begin
			eff_w = COL_W'(1);
		end else if (32'(width_q) > 32'(MAX_WIDTH)) begin
			eff_w = COL_W'(MAX_WIDTH);
		end else begin
			eff_w = COL_W'(width_q);
		end
		if (height_q == '0) begin
			eff_h = ROW_W'(1);
		end else if (32'(height_q) > 32'(MAX_HEIGHT)) begin
			eff_h = ROW_W'(MAX_HEIGHT);
		end else begin
			eff_h = ROW_W'(height_q);
		end
	end

	assign col_b = head.frame_rst ? '0 : col_q;
	assign row_b = head.frame_rst ? '0 : row_q;

	assign avail   = (col_b < eff_w) ? (eff_w - col_b) : '0;
	assign clipped = 32'(head.arg_a) > 32'(avail);
	assign run_len = clipped ? 8'(avail) : head.arg_a;
	assign row_out = (row_b >= eff_h);
	assign col_sum = 32'(col_b) + 32'(head.arg_a);
	assign row_sum = 32'(row_b) + 32'(head.arg_b);

	assign emits    = (head.op == OP_RUN) || (head.op == OP_EOI);
	assign out_free = !out_valid_q || out_ready;
	assign pop      = !fifo_stat.empty && out_free;

	always_comb begin
		col_d = col_b;
		row_d = row_b;
		res_d.row          = (32'(row_b) > 32'(ROW_OUT_MAX)) ? ROW_OUT_MAX : 12'(row_b);
		res_d.column       = (32'(col_b) > 32'(COL_OUT_MAX)) ? COL_OUT_MAX : 10'(col_b);
		res_d.run_length   = 8'd0;
		res_d.first_index  = 4'd0;
		res_d.second_index = 4'd0;
		res_d.end_of_image = 1'b0;
		res_d.overflow     = 1'b0;
		case (head.op)
			OP_RUN: begin
				col_d              = col_b + COL_W'(run_len);
				res_d.run_length   = row_out ? 8'd0 : run_len;
				res_d.first_index  = 4'((head.arg_b & HI_MASK) >> 4);
				res_d.second_index = 4'(head.arg_b & LO_MASK);
				res_d.overflow     = clipped || row_out;
			end
			OP_EOL: begin
				col_d = '0;
				row_d = (row_b < ROW_W'(MAX_HEIGHT)) ? row_b + 1'b1 : row_b;
			end
			OP_EOI: begin
				res_d.end_of_image = 1'b1;
			end
			OP_DELTA: begin
				col_d = (col_sum > 32'(eff_w)) ? eff_w : COL_W'(col_sum);
				row_d = (row_sum > 32'(MAX_HEIGHT)) ? ROW_W'(MAX_HEIGHT) : ROW_W'(row_sum);
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q       <= '0;
			row_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				col_q <= col_d;
				row_q <= row_d;
			end
			if (pop && emits) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop && emits) begin
			res_q <= res_d;
		end
	end

	assign out_valid = out_valid_q;
	assign res       = res_q;

endmodule

/* sv/bmp_rle4_decoder.sv */
`timescale 1ns / 1ps
// Each accepted byte's command is queued, then its result is registered at the output.
// Throughput: one compressed byte per cycle; the parser and the position unit
// each take one command per cycle, decoupled by a four-entry command queue.
// Output stalls back up through the queue to in_ready once it is full.
// Reset: parser, position and queue cleared; width 320, height 240.
// ----------------------------------------------------------------------------
// bmp_rle4_decoder
// 4-bit RLE bitmap stream decoder producing run descriptors.
// ----------------------------------------------------------------------------
module bmp_rle4_decoder (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic [7:0]                      data_byte,
	input  logic                            frame_start,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic [11:0]                     row,
	output logic [9:0]                      column,
	output logic [7:0]                      run_length,
	output logic [3:0]                      first_index,
	output logic [3:0]                      second_index,
	output logic                            end_of_image,
	output logic                            overflow,
	input  logic                            cfg_we,
	input  logic [rle4d_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [rle4d_pkg::CFG_W-1:0]     cfg_data
);
	import rle4d_pkg::*;

	cmd_t       push_cmd;
	cmd_t       head_cmd;
	logic       push;
	logic       pop;
	fifo_stat_t fifo_stat;
	result_t    res;

	rle4d_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.data_byte   (data_byte),
		.frame_start (frame_start),
		.fifo_stat   (fifo_stat),
		.push        (push),
		.cmd         (push_cmd)
	);

	rle4d_cmd_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wr_cmd (push_cmd),
		.pop    (pop),
		.rd_cmd (head_cmd),
		.stat   (fifo_stat)
	);

	rle4d_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.head      (head_cmd),
		.fifo_stat (fifo_stat),
		.pop       (pop),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.res       (res)
	);

	assign row          = res.row;
	assign column       = res.column;
	assign run_length   = res.run_length;
	assign first_index  = res.first_index;
	assign second_index = res.second_index;
	assign end_of_image = res.end_of_image;
	assign overflow     = res.overflow;

endmodule

/* sv/rle4d_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rle4d_checker
// Port-level checks on the decoder's run descriptors.
// ----------------------------------------------------------------------------
module rle4d_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_ready,
	input logic [11:0] row,
	input logic [9:0]  column,
	input logic [7:0]  run_length,
	input logic [3:0]  first_index,
	input logic [3:0]  second_index,
	input logic        end_of_image,
	input logic        overflow
);
	import rle4d_pkg::*;

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(row) && $stable(column)
			&& $stable(run_length) && $stable(end_of_image) && $stable(overflow))
		else $error("result changed while stalled");

	// end marker carries no pixels and no overflow
	a_eoi_empty: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && end_of_image |-> run_length == 8'd0 && overflow == 1'b0
			&& first_index == 4'd0 && second_index == 4'd0)
		else $error("end marker with run data");

	// an unclipped run on a valid row is never empty
	a_run_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !end_of_image && !overflow |-> run_length != 8'd0)
		else $error("empty run without overflow");

	// a written run stays inside the widest line
	a_run_in_line: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && run_length != 8'd0 |-> 32'(column) + 32'(run_length) <= 32'(MAX_WIDTH))
		else $error("run extends past line end");

endmodule

bind bmp_rle4_decoder rle4d_checker u_rle4d_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.out_valid    (out_valid),
	.out_ready    (out_ready),
	.row          (row),
	.column       (column),
	.run_length   (run_length),
	.first_index  (first_index),
	.second_index (second_index),
	.end_of_image (end_of_image),
	.overflow     (overflow)
);

/* sim/tb_bmp_rle4_decoder.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_bmp_rle4_decoder
// Self-checking bench for the 4-bit RLE bitmap decoder: drives compressed
// byte streams over the request handshake, predicts every run descriptor
// with an in-bench decoder and compares each accepted output in order.
// ----------------------------------------------------------------------------
import rle4d_pkg::*;

class run_scoreboard;
	logic [IMG_W_W-1:0] width_reg;
	logic [IMG_H_W-1:0] height_reg;
	phase_t             phase;
	logic [7:0]         held_count;
	logic [7:0]         delta_cols;
	logic [7:0]         abs_left;
	logic               pad_due;
	logic [COL_W-1:0]   cur_col;
	logic [ROW_W-1:0]   cur_row;
	logic               done;
	result_t            runs_due[$];
	int unsigned        decoded;
	int unsigned        errors;

	function new();
		width_reg  = WIDTH_RESET;
		height_reg = HEIGHT_RESET;
		decoded    = 0;
		errors     = 0;
		restart();
	endfunction

	function void restart();
		phase      = PH_COUNT;
		held_count = '0;
		delta_cols = '0;
		abs_left   = '0;
		pad_due    = 1'b0;
		cur_col    = '0;
		cur_row    = '0;
		done       = 1'b0;
	endfunction

	function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
		if (idx == REG_IMAGE_WIDTH)
			width_reg = val[IMG_W_W-1:0];
		else if (idx == REG_IMAGE_HEIGHT)
			height_reg = val[IMG_H_W-1:0];
	endfunction

	function int eff_width();
		int w;
		w = int'(width_reg);
		if (w == 0) w = 1;
		if (w > MAX_WIDTH) w = MAX_WIDTH;
		return w;
	endfunction

	function int eff_height();
		int h;
		h = int'(height_reg);
		if (h == 0) h = 1;
		if (h > MAX_HEIGHT) h = MAX_HEIGHT;
		return h;
	endfunction

	// position fields saturate at the output widths, everything else zero
	function result_t at_position();
		result_t r;
		r = '0;
		r.row    = (cur_row > ROW_OUT_MAX) ? ROW_OUT_MAX : cur_row[11:0];
		r.column = (cur_col > COL_OUT_MAX) ? COL_OUT_MAX : cur_col[9:0];
		return r;
	endfunction

	function void push_run(int req, logic [7:0] pix);
		int      c;
		int      avail;
		int      len;
		result_t r;
		c     = int'(cur_col);
		avail = (c < eff_width()) ? eff_width() - c : 0;
		len   = (req < avail) ? req : avail;
		r = at_position();
		r.run_length   = len[7:0];
		r.first_index  = 4'((pix & HI_MASK) >> 4);
		r.second_index = 4'(pix & LO_MASK);
		r.overflow     = (req > avail);
		if (int'(cur_row) >= eff_height()) begin
			r.overflow   = 1'b1;
			r.run_length = '0;
		end
		runs_due.push_back(r);
		cur_col = COL_W'(c + len);
	endfunction

	function void take_byte(logic [7:0] b, logic fs);
		int      len;
		int      pos;
		result_t r;
		if (fs) restart();
		if (done) return;
		decoded++;
		case (phase)
			PH_VALUE: begin
				phase = PH_COUNT;
				push_run(int'(held_count), b);
			end
			PH_ESCAPE: begin
				phase = PH_COUNT;
				if (b == ESC_EOL) begin
					cur_col = '0;
					if (cur_row < MAX_HEIGHT) cur_row = cur_row + 1'b1;
				end else if (b == ESC_EOI) begin
					done = 1'b1;
					r = at_position();
					r.end_of_image = 1'b1;
					runs_due.push_back(r);
				end else if (b == ESC_DELTA) begin
					phase = PH_DELTA_X;
				end else begin
					abs_left = b;
					// data bytes are padded to an even count
					pad_due  = (((int'(b) + 1) >> 1) & 1) != 0;
					phase    = PH_ABS_DATA;
				end
			end
			PH_DELTA_X: begin
				delta_cols = b;
				phase      = PH_DELTA_Y;
			end
			PH_DELTA_Y: begin
				pos = int'(cur_col) + int'(delta_cols);
				if (pos > eff_width()) pos = eff_width();
				cur_col = COL_W'(pos);
				pos = int'(cur_row) + int'(b);
				if (pos > MAX_HEIGHT) pos = MAX_HEIGHT;
				cur_row = ROW_W'(pos);
				phase   = PH_COUNT;
			end
			PH_ABS_DATA: begin
				len      = (int'(abs_left) < 2) ? int'(abs_left) : 2;
				abs_left = abs_left - 8'(len);
				if (abs_left == 0) phase = pad_due ? PH_ABS_PAD : PH_COUNT;
				push_run(len, b);
			end
			PH_ABS_PAD: begin
				pad_due = 1'b0;
				phase   = PH_COUNT;
			end
			default: begin
				if (b == 8'h00) begin
					phase = PH_ESCAPE;
				end else begin
					held_count = b;
					phase      = PH_VALUE;
				end
			end
		endcase
	endfunction

	function string show(result_t r);
		return $sformatf("row %0d col %0d len %0d idx %h/%h eoi %b ovf %b",
			r.row, r.column, r.run_length, r.first_index, r.second_index,
			r.end_of_image, r.overflow);
	endfunction

	function void check_run(result_t got);
		result_t want;
		if (runs_due.size() == 0) begin
			errors++;
			if (errors <= 10) $display("%0t: unexpected run: %s", $time, show(got));
			return;
		end
		want = runs_due.pop_front();
		if (got.row !== want.row || got.column !== want.column ||
				got.run_length !== want.run_length ||
				got.first_index !== want.first_index ||
				got.second_index !== want.second_index ||
				got.end_of_image !== want.end_of_image ||
				got.overflow !== want.overflow) begin
			errors++;
			if (errors <= 10) begin
				$display("%0t: run mismatch", $time);
				$display("  expected %s", show(want));
				$display("  actual   %s", show(got));
			end
		end
	endfunction
endclass

module tb_bmp_rle4_decoder;

	localparam logic [7:0]           ESC_MARK   = 8'h00;
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
	localparam int                   LONG_HOLD  = 100;
	localparam int                   DRAIN_TAIL = 10;
	localparam int                   NUM_PHASES = 7;

	localparam logic [CFG_W-1:0] PHASE_WIDTH [NUM_PHASES] =
		'{13'd1, 13'd1024, 13'd0, 13'd16, 13'd2047, 13'd320, 13'd320};
	localparam logic [CFG_W-1:0] PHASE_HEIGHT [NUM_PHASES] =
		'{13'd1, 13'd4096, 13'd0, 13'd8, 13'd8191, 13'd240, 13'd240};

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 in_valid;
	logic                 in_ready;
	logic [7:0]           data_byte;
	logic                 frame_start;
	logic                 out_valid;
	logic                 out_ready;
	logic [11:0]          row;
	logic [9:0]           column;
	logic [7:0]           run_length;
	logic [3:0]           first_index;
	logic [3:0]           second_index;
	logic                 end_of_image;
	logic                 overflow;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0]     cfg_data;

	run_scoreboard sb;
	result_t       seen_run;
	logic          next_fs;
	int unsigned   tx_gap_pct;
	int unsigned   rx_gap_pct;
	int unsigned   hold_reqs;
	int unsigned   holds_done;

	bmp_rle4_decoder i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.data_byte    (data_byte),
		.frame_start  (frame_start),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.row          (row),
		.column       (column),
		.run_length   (run_length),
		.first_index  (first_index),
		.second_index (second_index),
		.end_of_image (end_of_image),
		.overflow     (overflow),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			seen_run = '{row: row, column: column, run_length: run_length,
				first_index: first_index, second_index: second_index,
				end_of_image: end_of_image, overflow: overflow};
			sb.check_run(seen_run);
		end
	end

	// output side: random back-pressure plus the long hold-off on request
	initial begin
		out_ready  <= 1'b0;
		holds_done = 0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_reqs != holds_done) begin
				holds_done++;
				out_ready <= 1'b0;
				repeat (LONG_HOLD) @(posedge clk);
				out_ready <= 1'b1;
			end else if (rx_gap_pct != 0 && $urandom_range(0, 99) < rx_gap_pct) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(1, 12)) @(posedge clk);
				out_ready <= 1'b1;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	initial begin
		#5_000_000;
		$display("== FAIL ==");
		$finish;
	end

	task automatic send_byte(input logic [7:0] d);
		logic fs;
		fs      = next_fs;
		next_fs = 1'b0;
		if (tx_gap_pct != 0 && $urandom_range(0, 99) < tx_gap_pct) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 12)) @(posedge clk);
		end
		in_valid    <= 1'b1;
		data_byte   <= d;
		frame_start <= fs;
		do @(posedge clk); while (!in_ready);
		sb.take_byte(d, fs);
	endtask

	task automatic send_run(input logic [7:0] count, input logic [7:0] pix);
		send_byte(count);
		send_byte(pix);
	endtask

	task automatic send_escape(input logic [7:0] code);
		send_byte(ESC_MARK);
		send_byte(code);
	endtask

	task automatic send_delta(input logic [7:0] dx, input logic [7:0] dy);
		send_escape(ESC_DELTA);
		send_byte(dx);
		send_byte(dy);
	endtask

	task automatic send_abs(input logic [7:0] n);
		int nbytes;
		nbytes = (int'(n) + 1) / 2;
		send_escape(n);
		repeat (nbytes) send_byte(8'($urandom_range(0, 255)));
		if (nbytes % 2 != 0) send_byte(8'($urandom_range(0, 255)));
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		sb.write_reg(idx, val);
	endtask

	task automatic wait_drain();
		in_valid <= 1'b0;
		while (sb.runs_due.size() != 0) @(posedge clk);
		// bytes with no run may still be in the command queue
		repeat (DRAIN_TAIL) @(posedge clk);
	endtask

	task automatic directed_bytes();
		next_fs = 1'b1;
		send_run(8'd255, 8'hFF);
		send_run(8'd255, 8'hA5);       // clipped at line end
		send_run(8'd1, 8'h5A);         // column already at width
		send_escape(ESC_EOL);
		send_abs(8'd5);                // odd data byte count, pad follows
		send_delta(8'd255, 8'd255);    // lands past the height
		send_run(8'd2, 8'h3C);
		send_escape(ESC_EOI);
		send_byte(8'h07);              // ignored until next frame start
		send_byte(8'hFF);
	endtask

	// drive column and row into saturation; needs the widest setting
	task automatic far_corner();
		next_fs = 1'b1;
		repeat (5) send_delta(8'd255, 8'd0);
		send_run(8'd3, 8'h12);
		repeat (17) send_delta(8'd0, 8'd255);
		send_run(8'd1, 8'h34);
		send_escape(ESC_EOL);
		send_run(8'd4, 8'hC3);
	endtask

	task automatic random_stream(input int unsigned quota);
		int unsigned stop;
		int unsigned pick;
		stop    = sb.decoded + quota;
		next_fs = 1'b1;
		while (sb.decoded < stop) begin
			pick = $urandom_range(0, 99);
			if (pick < 45) begin
				send_run(8'(($urandom_range(0, 9) == 0) ? $urandom_range(1, 255)
					: $urandom_range(1, 16)), 8'($urandom_range(0, 255)));
			end else if (pick < 65) begin
				send_abs(8'(($urandom_range(0, 7) == 0) ? $urandom_range(3, 255)
					: $urandom_range(3, 12)));
			end else if (pick < 77) begin
				send_escape(ESC_EOL);
			end else if (pick < 88) begin
				send_delta(8'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 255)
					: $urandom_range(0, 8)),
					8'(($urandom_range(0, 5) == 0) ? $urandom_range(0, 255)
					: $urandom_range(0, 2)));
			end else if (pick < 92) begin
				send_escape(ESC_EOI);
				repeat ($urandom_range(0, 3)) send_byte(8'($urandom_range(0, 255)));
				next_fs = 1'b1;
			end else if (pick < 97) begin
				send_byte(8'($urandom_range(0, 255)));
			end else begin
				// cut the sequence short and restart the frame
				send_byte(8'($urandom_range(0, 255)));
				next_fs = 1'b1;
			end
		end
	endtask

	initial begin
		logic [CFG_W-1:0] w;
		logic [CFG_W-1:0] h;
		sb          = new();
		next_fs     = 1'b0;
		tx_gap_pct  = 20;
		rx_gap_pct  = 20;
		hold_reqs   <= 0;
		arst_n      <= 1'b0;
		in_valid    <= 1'b0;
		data_byte   <= '0;
		frame_start <= 1'b0;
		cfg_we      <= 1'b0;
		cfg_index   <= '0;
		cfg_data    <= '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		directed_bytes();
		wait_drain();
		write_reg(REG_IMAGE_WIDTH, 13'd2047);
		write_reg(REG_IMAGE_HEIGHT, 13'd8191);
		far_corner();

		for (int p = 0; p < NUM_PHASES; p++) begin
			wait_drain();
			w = PHASE_WIDTH[p];
			h = PHASE_HEIGHT[p];
			if (p == 5) begin
				w = CFG_W'($urandom_range(1, 100));
				h = CFG_W'($urandom_range(1, 30));
			end
			write_reg(REG_IMAGE_WIDTH, w);
			write_reg(REG_IMAGE_HEIGHT, h);
			if (p == 3) write_reg(REG_UNUSED, CFG_W'($urandom_range(0, 8191)));
			if (p == NUM_PHASES - 1) begin
				tx_gap_pct = 0;
				rx_gap_pct = 0;
			end else begin
				tx_gap_pct = 8 * $urandom_range(0, 3);
				rx_gap_pct = 8 * $urandom_range(0, 3);
			end
			if (p == 1) begin
				// output held off while input keeps coming: queue fills up
				hold_reqs <= hold_reqs + 1;
				next_fs = 1'b1;
				repeat (20) send_run(8'($urandom_range(1, 40)), 8'($urandom_range(0, 255)));
				wait_drain();
			end
			random_stream(75);
		end
		wait_drain();

		if (sb.errors == 0 && sb.runs_due.size() == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
